[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the debug-bus frame master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define C2FM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define C2FM_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define C2FM_ASSERT(lbl, clk, rst, prop, msg)

`define C2FM_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

[src/c2fm_pkg.sv]
// Types and constants of the two-wire debug-bus frame master.
`default_nettype none

package c2fm_pkg;

  // Operation codes; the command field uses the same values.
  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_AW   = 3'd1,
    OP_AR   = 3'd2,
    OP_DW   = 3'd3,
    OP_DR   = 3'd4,
    OP_RST  = 3'd5
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WAIT_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_RESET_LOW     = 2'd1;
  localparam logic [1:0] CFG_RESET_RECOVER = 2'd2;

  localparam logic [15:0] WAIT_LIMIT_RST    = 16'd1000;
  localparam logic [7:0]  RESET_LOW_RST     = 8'd20;
  localparam logic [7:0]  RESET_RECOVER_RST = 8'd2;

  // Instruction codes sent after START.
  localparam logic [1:0] INS_AW = 2'b11;
  localparam logic [1:0] INS_AR = 2'b10;
  localparam logic [1:0] INS_DW = 2'b01;
  localparam logic [1:0] INS_DR = 2'b00;

  // Frame phase landmarks.
  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_INS_LAST  = 4'd2;
  localparam logic [3:0] PH_ADDR_BIT0 = 4'd3;
  localparam logic [3:0] PH_LEN_LAST  = 4'd4;
  localparam logic [3:0] PH_DATA_BIT0 = 4'd5;
  localparam logic [3:0] PH_DR_WAIT   = 4'd6;
  localparam logic [3:0] PH_DW_LAST   = 4'd12;
  localparam logic [3:0] PH_DW_WAIT   = 4'd14;
  localparam logic [3:0] PH_ADDR_STOP = 4'd11;
  localparam logic [3:0] PH_DATA_STOP = 4'd15;
  // Windows in which a sampled read bit arrives.
  localparam logic [3:0] PH_AR_RX_FIRST = 4'd4;
  localparam logic [3:0] PH_DR_RX_FIRST = 4'd8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] wr_byte;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       clk_strobe;
    logic       clk_hold_low;
    logic       clk_drive_en;
    logic       line_out;
    logic       line_drive_en;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_byte;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] wait_limit_ticks;
    logic [7:0]  reset_low_ticks;
    logic [7:0]  reset_recover_ticks;
  } cfg_t;

endpackage

`default_nettype wire

[src/c2fm_cfg_regs.sv]
// Configuration register file of the debug-bus frame master.
`default_nettype none

module c2fm_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [15:0]   wr_data,
  output c2fm_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_limit_ticks    <= c2fm_pkg::WAIT_LIMIT_RST;
      cfg.reset_low_ticks     <= c2fm_pkg::RESET_LOW_RST;
      cfg.reset_recover_ticks <= c2fm_pkg::RESET_RECOVER_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        c2fm_pkg::CFG_WAIT_LIMIT:    cfg.wait_limit_ticks    <= wr_data;
        c2fm_pkg::CFG_RESET_LOW:     cfg.reset_low_ticks     <= wr_data[7:0];
        c2fm_pkg::CFG_RESET_RECOVER: cfg.reset_recover_ticks <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/c2fm_seq.sv]
// Frame sequencer: bus state, one-tick step logic and the result register.
`default_nettype none

module c2fm_seq #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire c2fm_pkg::in_item_t  item,
  input  wire c2fm_pkg::cfg_t      cfg,
  output logic                     res_free,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output c2fm_pkg::out_item_t      res
);

  localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  c2fm_pkg::op_t            operation, op_next;
  logic [3:0]               phase, phase_next;
  logic [7:0]               shift_byte, shift_byte_next;
  logic [COUNT_WIDTH-1:0]   tick_count, tick_count_next;
  logic                     timed_out, timed_out_next;
  c2fm_pkg::out_item_t      res_next;

  logic [LW-1:0]            wait_ext;
  logic [LW-1:0]            max_ext;
  logic [COUNT_WIDTH-1:0]   wait_lim, low_lim, rec_lim;

  // Effective limits: zero acts as one, and a WAIT limit above the counter
  // range acts as the counter's largest value.
  always_comb begin
    wait_ext = LW'(cfg.wait_limit_ticks);
    max_ext  = LW'({COUNT_WIDTH{1'b1}});
    if (wait_ext == '0) begin
      wait_lim = COUNT_WIDTH'(1);
    end else if (wait_ext > max_ext) begin
      wait_lim = {COUNT_WIDTH{1'b1}};
    end else begin
      wait_lim = COUNT_WIDTH'(wait_ext);
    end
    low_lim = (cfg.reset_low_ticks == 8'd0) ? COUNT_WIDTH'(1) :
              COUNT_WIDTH'(cfg.reset_low_ticks);
    rec_lim = (cfg.reset_recover_ticks == 8'd0) ? COUNT_WIDTH'(1) :
              COUNT_WIDTH'(cfg.reset_recover_ticks);
  end

  always_comb begin
    logic       run;
    logic       go;
    logic       data_op;
    logic       rd_op;
    logic [3:0] stop_p;
    logic [3:0] loop_p;
    logic [1:0] ins;
    logic       ins_bit;

    res_next        = '0;
    op_next         = operation;
    phase_next      = phase;
    shift_byte_next = shift_byte;
    tick_count_next = tick_count;
    timed_out_next  = timed_out;
    run             = 1'b1;
    go              = 1'b1;
    ins_bit         = 1'b0;

    if (operation == c2fm_pkg::OP_IDLE) begin
      if (item.cmd >= 3'(c2fm_pkg::OP_AW) && item.cmd <= 3'(c2fm_pkg::OP_RST)) begin
        op_next         = c2fm_pkg::op_t'(item.cmd);
        phase_next      = c2fm_pkg::PH_START;
        tick_count_next = '0;
        timed_out_next  = 1'b0;
        shift_byte_next = (op_next == c2fm_pkg::OP_AW || op_next == c2fm_pkg::OP_DW) ?
                          item.wr_byte : 8'h00;
      end else begin
        run = 1'b0;
      end
    end

    data_op = (op_next == c2fm_pkg::OP_DW) || (op_next == c2fm_pkg::OP_DR);
    rd_op   = (op_next == c2fm_pkg::OP_AR) || (op_next == c2fm_pkg::OP_DR);
    stop_p  = data_op ? c2fm_pkg::PH_DATA_STOP : c2fm_pkg::PH_ADDR_STOP;
    loop_p  = (op_next == c2fm_pkg::OP_DW) ? c2fm_pkg::PH_DW_WAIT : c2fm_pkg::PH_DR_WAIT;
    unique case (op_next)
      c2fm_pkg::OP_AW: ins = c2fm_pkg::INS_AW;
      c2fm_pkg::OP_AR: ins = c2fm_pkg::INS_AR;
      c2fm_pkg::OP_DW: ins = c2fm_pkg::INS_DW;
      default:         ins = c2fm_pkg::INS_DR;
    endcase

    if (run && op_next == c2fm_pkg::OP_RST) begin
      // Pin reset: hold the clock low, then drive it high to recover.
      res_next.clk_drive_en = 1'b1;
      if (tick_count_next != {COUNT_WIDTH{1'b1}}) begin
        tick_count_next = tick_count_next + COUNT_WIDTH'(1);
      end
      if (phase_next == c2fm_pkg::PH_START) begin
        res_next.clk_hold_low = 1'b1;
        res_next.busy_res     = 1'b1;
        if (tick_count_next >= low_lim) begin
          phase_next      = 4'd1;
          tick_count_next = '0;
        end
      end else if (tick_count_next >= rec_lim) begin
        res_next.done_res = 1'b1;
        op_next           = c2fm_pkg::OP_IDLE;
        phase_next        = c2fm_pkg::PH_START;
        tick_count_next   = '0;
      end else begin
        res_next.busy_res = 1'b1;
      end
    end else if (run) begin
      // The line level of the previous receive strobe arrives with this tick.
      if ((op_next == c2fm_pkg::OP_AR && phase_next >= c2fm_pkg::PH_AR_RX_FIRST &&
           phase_next <= c2fm_pkg::PH_ADDR_STOP) ||
          (op_next == c2fm_pkg::OP_DR && phase_next >= c2fm_pkg::PH_DR_RX_FIRST)) begin
        shift_byte_next = {item.line_in, shift_byte_next[7:1]};
      end

      if (data_op && phase_next == loop_p) begin
        if (!item.line_in && tick_count_next < wait_lim) begin
          res_next.clk_strobe   = 1'b1;
          res_next.clk_drive_en = 1'b1;
          res_next.busy_res     = 1'b1;
          if (tick_count_next != {COUNT_WIDTH{1'b1}}) begin
            tick_count_next = tick_count_next + COUNT_WIDTH'(1);
          end
          go = 1'b0;
        end else begin
          if (!item.line_in) begin
            timed_out_next = 1'b1;
          end
          phase_next = loop_p + 4'd1;
        end
      end

      if (go) begin
        res_next.clk_strobe   = 1'b1;
        res_next.clk_drive_en = 1'b1;
        res_next.busy_res     = 1'b1;
        ins_bit = (phase_next == 4'd1) ? ins[0] : ins[1];
        if (phase_next == c2fm_pkg::PH_START) begin
          phase_next = phase_next + 4'd1;
        end else if (phase_next <= c2fm_pkg::PH_INS_LAST) begin
          res_next.line_drive_en = 1'b1;
          res_next.line_out      = ins_bit;
          phase_next             = phase_next + 4'd1;
        end else if (phase_next == stop_p) begin
          res_next.busy_res = 1'b0;
          res_next.done_res = 1'b1;
          res_next.rd_byte  = rd_op ? shift_byte_next : 8'h00;
          res_next.status   = data_op & timed_out_next;
          op_next           = c2fm_pkg::OP_IDLE;
          phase_next        = c2fm_pkg::PH_START;
        end else if (op_next == c2fm_pkg::OP_AW) begin
          res_next.line_drive_en = 1'b1;
          res_next.line_out =
            shift_byte_next[3'(phase_next - c2fm_pkg::PH_ADDR_BIT0)];
          phase_next = phase_next + 4'd1;
        end else if (op_next == c2fm_pkg::OP_AR) begin
          phase_next = phase_next + 4'd1;
        end else if (phase_next <= c2fm_pkg::PH_LEN_LAST) begin
          // Length field: two zero bits.
          res_next.line_drive_en = 1'b1;
          phase_next             = phase_next + 4'd1;
        end else if (op_next == c2fm_pkg::OP_DW) begin
          if (phase_next <= c2fm_pkg::PH_DW_LAST) begin
            res_next.line_drive_en = 1'b1;
            res_next.line_out =
              shift_byte_next[3'(phase_next - c2fm_pkg::PH_DATA_BIT0)];
          end else begin
            tick_count_next = COUNT_WIDTH'(1);
          end
          phase_next = phase_next + 4'd1;
        end else begin
          if (phase_next == c2fm_pkg::PH_DATA_BIT0) begin
            tick_count_next = COUNT_WIDTH'(1);
          end
          phase_next = phase_next + 4'd1;
        end
      end
    end
  end

  assign res_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation  <= c2fm_pkg::OP_IDLE;
      phase      <= c2fm_pkg::PH_START;
      shift_byte <= 8'h00;
      tick_count <= '0;
      timed_out  <= 1'b0;
      res_valid  <= 1'b0;
    end else if (take) begin
      operation  <= op_next;
      phase      <= phase_next;
      shift_byte <= shift_byte_next;
      tick_count <= tick_count_next;
      timed_out  <= timed_out_next;
      res_valid  <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

[src/c2_frame_master_unit.sv]
// Top level of the two-wire debug-bus frame master.
//
// Each input transfer is one bus tick: a command, a byte to send and the
// data-line level sampled after the previous clock strobe. Each tick gives
// exactly one result transfer with the clock strobe, clock hold and driver
// enables, the data level to drive, and busy/done flags; read frames give
// the received byte and data frames the WAIT timeout status on their done
// tick. Commands arriving while a frame or pin reset is running are ignored.
// An item passes an input register and then the step logic into the result
// register; a new tick is accepted every cycle while the result side keeps
// up.
// When the receiver stalls, the result register holds and the input
// register keeps one more tick; beyond that in_ready drops.
// The configuration port is always ready; the user must write it only while
// the bus is idle, which the block does not enforce. An index beyond the register list is ignored.
// Synchronous reset empties both registers, returns the sequencer to idle
// and loads the configuration registers with their default values.
`default_nettype none
`include "assert_macros.svh"

module c2_frame_master_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire c2fm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output c2fm_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  c2fm_pkg::cfg_t      cfg;
  c2fm_pkg::in_item_t  s1_item;
  logic                s1_valid;
  logic                res_free;
  logic                adv;

  assign cfg_ready = 1'b1;

  c2fm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The input register moves on whenever the result register can take a
  // new tick, so the two sides only couple through one spare slot.
  assign adv      = s1_valid && res_free;
  assign in_ready = !s1_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  c2fm_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .take      (adv),
    .item      (s1_item),
    .cfg       (cfg),
    .res_free  (res_free),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (out_data)
  );

  // A held tick in the input register must not change while it waits.
  `C2FM_ASSERT(a_s1_hold, clk, rst, (s1_valid && !adv) |=> (s1_valid && $stable(s1_item)), "input register lost or changed a waiting tick")
  // A finished frame or reset never reports that it continues.
  `C2FM_NEVER(a_done_busy, clk, rst, out_valid && out_data.done_res && out_data.busy_res, "done and busy in the same tick")
  // Timeout status and a read byte appear only on a done tick.
  `C2FM_NEVER(a_status_done, clk, rst, out_valid && !out_data.done_res && (out_data.status || out_data.rd_byte != 8'h00), "status or read byte outside a done tick")
  // The data line is driven only together with a clock strobe.
  `C2FM_NEVER(a_drive_strobe, clk, rst, out_valid && out_data.line_drive_en && !out_data.clk_strobe, "data driven without a strobe")

endmodule

`default_nettype wire

[tb/c2fm_checker.sv]
// Scoreboard for the debug-bus frame master: predicts every tick and checks the results.
module c2fm_checker #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  c2fm_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  c2fm_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            pending,
  output logic                          seq_busy,
  output int                            fail_count,
  output int                            results_checked,
  output int                            frames_done,
  output int                            timeouts
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam int REPORT_LIMIT = 10;
  localparam logic [3:0] RST_LOW     = 4'd0;
  localparam logic [3:0] RST_RECOVER = 4'd1;

  // Predicted sequencer state and the register values it runs with.
  c2fm_pkg::op_t   cur_op;
  logic [3:0]      phase_q;
  logic [7:0]      shift_q;
  longint unsigned ticks_q;
  logic            late_q;
  logic [15:0]     wait_limit;
  logic [7:0]      low_ticks;
  logic [7:0]      recover_ticks;

  c2fm_pkg::out_item_t tick_results[$];
  c2fm_pkg::out_item_t want;

  // A register value of zero counts as one; the counter cannot pass its own range.
  function automatic longint unsigned limit_of(logic [15:0] v);
    longint unsigned lim;
    lim = (v == '0) ? 64'd1 : 64'(v);
    return (lim > COUNT_MAX) ? COUNT_MAX : lim;
  endfunction

  function automatic void count_tick();
    if (ticks_q < COUNT_MAX) ticks_q = ticks_q + 64'd1;
  endfunction

  function automatic logic byte_bit(logic [7:0] b, logic [3:0] idx);
    return b[idx[2:0]];
  endfunction

  function automatic c2fm_pkg::out_item_t strobe_item(logic drive, logic level);
    c2fm_pkg::out_item_t o;
    o = '0;
    o.clk_strobe    = 1'b1;
    o.clk_drive_en  = 1'b1;
    o.line_drive_en = drive;
    o.line_out      = drive & level;
    o.busy_res      = 1'b1;
    return o;
  endfunction

  function automatic c2fm_pkg::out_item_t predict_tick(c2fm_pkg::in_item_t it);
    c2fm_pkg::out_item_t o;
    logic                data_op;
    logic [3:0]          wait_ph;
    logic [3:0]          stop_ph;
    logic [1:0]          ins;
    o = '0;
    if (cur_op == c2fm_pkg::OP_IDLE) begin
      if (it.cmd < c2fm_pkg::OP_AW || it.cmd > c2fm_pkg::OP_RST) return o;
      cur_op  = c2fm_pkg::op_t'(it.cmd);
      phase_q = c2fm_pkg::PH_START;
      ticks_q = 64'd0;
      late_q  = 1'b0;
      shift_q = (cur_op == c2fm_pkg::OP_AW || cur_op == c2fm_pkg::OP_DW) ?
                it.wr_byte : 8'h00;
    end

    // Pin reset holds the clock low, then drives it high while the target recovers.
    if (cur_op == c2fm_pkg::OP_RST) begin
      o.clk_drive_en = 1'b1;
      count_tick();
      if (phase_q == RST_LOW) begin
        o.clk_hold_low = 1'b1;
        o.busy_res     = 1'b1;
        if (ticks_q >= limit_of({8'h00, low_ticks})) begin
          phase_q = RST_RECOVER;
          ticks_q = 64'd0;
        end
      end else if (ticks_q >= limit_of({8'h00, recover_ticks})) begin
        o.done_res = 1'b1;
        cur_op     = c2fm_pkg::OP_IDLE;
        phase_q    = c2fm_pkg::PH_START;
        ticks_q    = 64'd0;
      end else begin
        o.busy_res = 1'b1;
      end
      return o;
    end

    // A received bit arrives one tick after its strobe.
    if ((cur_op == c2fm_pkg::OP_AR && phase_q >= c2fm_pkg::PH_AR_RX_FIRST &&
         phase_q <= c2fm_pkg::PH_ADDR_STOP) ||
        (cur_op == c2fm_pkg::OP_DR && phase_q >= c2fm_pkg::PH_DR_RX_FIRST &&
         phase_q <= c2fm_pkg::PH_DATA_STOP)) begin
      shift_q = {it.line_in, shift_q[7:1]};
    end

    data_op = (cur_op == c2fm_pkg::OP_DW || cur_op == c2fm_pkg::OP_DR);
    wait_ph = (cur_op == c2fm_pkg::OP_DW) ? c2fm_pkg::PH_DW_WAIT : c2fm_pkg::PH_DR_WAIT;
    if (data_op && phase_q == wait_ph) begin
      if (!it.line_in && ticks_q < limit_of(wait_limit)) begin
        count_tick();
        return strobe_item(1'b0, 1'b0);
      end
      if (!it.line_in) late_q = 1'b1;
      phase_q = wait_ph + 4'd1;
    end

    stop_ph = data_op ? c2fm_pkg::PH_DATA_STOP : c2fm_pkg::PH_ADDR_STOP;
    case (cur_op)
      c2fm_pkg::OP_AW: ins = c2fm_pkg::INS_AW;
      c2fm_pkg::OP_AR: ins = c2fm_pkg::INS_AR;
      c2fm_pkg::OP_DW: ins = c2fm_pkg::INS_DW;
      default:         ins = c2fm_pkg::INS_DR;
    endcase

    if (phase_q == c2fm_pkg::PH_START) begin
      o = strobe_item(1'b0, 1'b0);
    end else if (phase_q <= c2fm_pkg::PH_INS_LAST) begin
      o = strobe_item(1'b1, ins[phase_q == c2fm_pkg::PH_INS_LAST]);
    end else if (phase_q == stop_ph) begin
      o = strobe_item(1'b0, 1'b0);
      o.busy_res = 1'b0;
      o.done_res = 1'b1;
      if (cur_op == c2fm_pkg::OP_AR || cur_op == c2fm_pkg::OP_DR) o.rd_byte = shift_q;
      if (data_op) o.status = late_q;
      cur_op  = c2fm_pkg::OP_IDLE;
      phase_q = c2fm_pkg::PH_START;
      return o;
    end else if (cur_op == c2fm_pkg::OP_AW) begin
      o = strobe_item(1'b1, byte_bit(shift_q, phase_q - c2fm_pkg::PH_ADDR_BIT0));
    end else if (cur_op == c2fm_pkg::OP_AR) begin
      o = strobe_item(1'b0, 1'b0);
    end else if (phase_q <= c2fm_pkg::PH_LEN_LAST) begin
      o = strobe_item(1'b1, 1'b0);
    end else if (cur_op == c2fm_pkg::OP_DW) begin
      if (phase_q <= c2fm_pkg::PH_DW_LAST) begin
        o = strobe_item(1'b1, byte_bit(shift_q, phase_q - c2fm_pkg::PH_DATA_BIT0));
      end else begin
        o = strobe_item(1'b0, 1'b0);
        ticks_q = 64'd1;
      end
    end else begin
      o = strobe_item(1'b0, 1'b0);
      if (phase_q == c2fm_pkg::PH_DATA_BIT0) ticks_q = 64'd1;
    end
    phase_q = phase_q + 4'd1;
    return o;
  endfunction

  function automatic string show(c2fm_pkg::out_item_t r);
    return $sformatf("stb=%b hold=%b clk_en=%b line=%b line_en=%b busy=%b done=%b rd=%h st=%b",
                     r.clk_strobe, r.clk_hold_low, r.clk_drive_en, r.line_out,
                     r.line_drive_en, r.busy_res, r.done_res, r.rd_byte, r.status);
  endfunction

  task automatic flag(string why);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, why);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_op          = c2fm_pkg::OP_IDLE;
      phase_q         = c2fm_pkg::PH_START;
      shift_q         = '0;
      ticks_q         = 64'd0;
      late_q          = 1'b0;
      wait_limit      = c2fm_pkg::WAIT_LIMIT_RST;
      low_ticks       = c2fm_pkg::RESET_LOW_RST;
      recover_ticks   = c2fm_pkg::RESET_RECOVER_RST;
      fail_count      = 0;
      results_checked = 0;
      frames_done     = 0;
      timeouts        = 0;
      tick_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          c2fm_pkg::CFG_WAIT_LIMIT:    wait_limit    = cfg_data;
          c2fm_pkg::CFG_RESET_LOW:     low_ticks     = cfg_data[7:0];
          c2fm_pkg::CFG_RESET_RECOVER: recover_ticks = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (tick_results.size() == 0) begin
          flag($sformatf("result with no tick outstanding: %s", show(out_data)));
        end else begin
          want = tick_results.pop_front();
          results_checked++;
          if (out_data !== want) begin
            flag($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                           results_checked, show(want), show(out_data)));
          end
          if (want.done_res) frames_done++;
          if (want.status) timeouts++;
        end
      end
      if (in_valid && in_ready) tick_results.push_back(predict_tick(in_data));
    end
    pending  <= tick_results.size();
    seq_busy <= (cur_op != c2fm_pkg::OP_IDLE);
  end

endmodule

[tb/tb_c2_frame_master_unit.sv]
// Testbench top for the debug-bus frame master: stimulus, receiver stalls and verdict.
module tb_c2_frame_master_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Rough number of ticks driven during the random part, spread over the
  // register settings below.
  localparam int ITEMS_TARGET = 1150;
  localparam int SETTINGS_RUN = 5;

  // Register index past the end of the list; the block must ignore it.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Command values that are not commands; they act like a plain tick.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  c2fm_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  c2fm_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = c2fm_pkg::CFG_WAIT_LIMIT;
  logic [15:0]         cfg_data  = '0;

  // Figures handed up by the checker.
  int   pending;
  logic seq_busy;
  int   fail_count;
  int   results_checked;
  int   frames_done;
  int   timeouts;

  // Idling controls: percent chance of a sender gap before a tick and of a
  // receiver stall starting on a cycle. Both are reshuffled during the run.
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;

  int ticks_sent = 0;   // every tick transfer into the block
  int body_items = 0;   // ticks that start or carry a frame or pin reset
  int wait_now   = c2fm_pkg::WAIT_LIMIT_RST;   // WAIT limit in force, zero counted as one

  always #2 clk = ~clk;

  c2_frame_master_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  c2fm_checker CHK (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending         (pending),
    .seq_busy        (seq_busy),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .frames_done     (frames_done),
    .timeouts        (timeouts)
  );

  // Idle stretches are mostly short, now and then much longer.
  function automatic int pick_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic coin(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Receiver side: ready drops for random stretches. One assignment per edge.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (coin(stall_pct)) begin
      stall_left = pick_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One tick transfer. Valid is raised at a clock edge and held with the same
  // payload until the block takes it; the task returns at the edge of the
  // transfer, leaving valid high so the next tick can follow directly.
  task automatic push_tick(logic [2:0] cmd, logic [7:0] wr, logic line);
    c2fm_pkg::in_item_t it;
    int                 gap;
    it.cmd     = cmd;
    it.wr_byte = wr;
    it.line_in = line;
    gap = coin(gap_pct) ? pick_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Start a frame or pin reset and keep feeding ticks until the sequencer is
  // idle again. The line is high on line_pct percent of the ticks, which
  // decides both the received bits and how long a WAIT field lasts. Ticks
  // inside the frame carry a random command junk_pct percent of the time;
  // the block has to ignore those. The busy flag trails by one tick, so a
  // frame may be followed by one extra tick.
  task automatic run_frame(logic [2:0] cmd, logic [7:0] wr, int line_pct, int junk_pct);
    logic [2:0] noise;
    push_tick(cmd, wr, coin(line_pct));
    body_items++;
    do begin
      noise = coin(junk_pct) ? 3'($urandom_range(7)) : c2fm_pkg::OP_IDLE;
      push_tick(noise, 8'($urandom_range(255)), coin(line_pct));
      body_items++;
    end while (seq_busy);
  endtask

  // Bring the block to rest: finish any frame still running, then wait until
  // every result has come back from the two-stage pipe.
  task automatic settle_bus();
    in_valid <= 1'b0;
    @(posedge clk);
    while (seq_busy) begin
      push_tick(c2fm_pkg::OP_IDLE, 8'($urandom_range(255)), coin(70));
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Valid stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load a full register setting while the block is at rest. The unused
  // upper bits of the eight-bit registers get random values, and a write to
  // the index past the list goes in first.
  task automatic apply_setting(logic [15:0] wlim, logic [7:0] low, logic [7:0] rec);
    logic [7:0] pad_low;
    logic [7:0] pad_rec;
    pad_low = 8'($urandom_range(255));
    pad_rec = 8'($urandom_range(255));
    settle_bus();
    write_reg(CFG_SPARE, 16'($urandom_range(16'hFFFF)));
    write_reg(c2fm_pkg::CFG_WAIT_LIMIT, wlim);
    write_reg(c2fm_pkg::CFG_RESET_LOW, {pad_low, low});
    write_reg(c2fm_pkg::CFG_RESET_RECOVER, {pad_rec, rec});
    cfg_valid <= 1'b0;
    wait_now = (wlim == '0) ? 1 : int'(wlim);
  endtask

  // Mostly whole frames with random content. A line held low through a
  // frame forces WAIT timeouts, but only where the limit is small enough to
  // run out in reasonable time. Plain ticks with non-commands are mixed in
  // and are not counted.
  task automatic random_traffic(int budget);
    int            stop_at;
    int            pick;
    int            line_pct;
    logic [7:0]    wr;
    logic [2:0]    idle_cmd;
    c2fm_pkg::op_t op;
    stop_at = body_items + budget;
    while (body_items < stop_at) begin
      if ($urandom_range(15) == 0) begin
        case ($urandom_range(3))
          0: gap_pct = 0;
          1: gap_pct = 10;
          2: gap_pct = 30;
          default: gap_pct = 60;
        endcase
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end
      pick = $urandom_range(99);
      wr   = 8'($urandom_range(255));
      if (wait_now <= 64 && coin(30)) line_pct = 0;
      else line_pct = $urandom_range(80, 20);
      if (pick < 8) begin
        idle_cmd = 3'($urandom_range(7));
        if (idle_cmd >= c2fm_pkg::OP_AW && idle_cmd <= c2fm_pkg::OP_RST) begin
          idle_cmd = c2fm_pkg::OP_IDLE;
        end
        push_tick(idle_cmd, wr, coin(50));
      end else if (pick < 14) begin
        run_frame(c2fm_pkg::OP_RST, wr, line_pct, 15);
      end else begin
        case (pick % 4)
          0: op = c2fm_pkg::OP_AW;
          1: op = c2fm_pkg::OP_AR;
          2: op = c2fm_pkg::OP_DW;
          default: op = c2fm_pkg::OP_DR;
        endcase
        run_frame(op, wr, line_pct, 15);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first with the registers at their reset values.
    // Ticks carrying no command, including the two spare command codes.
    push_tick(CMD_SPARE_LO, 8'h00, 1'b0);
    push_tick(CMD_SPARE_HI, 8'hFF, 1'b1);
    push_tick(c2fm_pkg::OP_IDLE, 8'hAA, 1'b1);
    gap_pct   = 25;
    stall_pct = 25;
    // Address writes with all-zero and all-one bytes.
    run_frame(c2fm_pkg::OP_AW, 8'h00, 50, 0);
    run_frame(c2fm_pkg::OP_AW, 8'hFF, 50, 0);
    // Address reads with the line stuck high and stuck low.
    run_frame(c2fm_pkg::OP_AR, 8'h5A, 100, 0);
    run_frame(c2fm_pkg::OP_AR, 8'h00, 0, 0);
    // Data write whose WAIT field ends at once, then one that sees random
    // commands on every tick while it runs.
    run_frame(c2fm_pkg::OP_DW, 8'hA5, 100, 0);
    run_frame(c2fm_pkg::OP_DW, 8'h5A, 100, 100);
    run_frame(c2fm_pkg::OP_DR, 8'h00, 100, 0);
    run_frame(c2fm_pkg::OP_DR, 8'hFF, 50, 0);
    run_frame(c2fm_pkg::OP_RST, 8'h00, 50, 100);

    // Smallest limits: WAIT times out after one strobe, and the timed-out
    // read still shifts in its eight bits.
    apply_setting(16'd1, 8'd1, 8'd1);
    run_frame(c2fm_pkg::OP_DW, 8'hFF, 0, 0);
    run_frame(c2fm_pkg::OP_DR, 8'h00, 0, 0);
    run_frame(c2fm_pkg::OP_RST, 8'h00, 50, 0);

    // Registers written as zero behave as one.
    apply_setting(16'd0, 8'd0, 8'd0);
    run_frame(c2fm_pkg::OP_DR, 8'h00, 0, 0);
    run_frame(c2fm_pkg::OP_RST, 8'h00, 50, 0);
    run_frame(c2fm_pkg::OP_DW, 8'h3C, 0, 0);

    // Random part, one share of the tick budget per register setting.
    apply_setting(c2fm_pkg::WAIT_LIMIT_RST, c2fm_pkg::RESET_LOW_RST,
                  c2fm_pkg::RESET_RECOVER_RST);
    random_traffic(ITEMS_TARGET / SETTINGS_RUN);
    apply_setting(16'hFFFF, 8'hFF, 8'hFF);
    random_traffic(ITEMS_TARGET / SETTINGS_RUN);
    apply_setting(16'd1, 8'd1, 8'd1);
    random_traffic(ITEMS_TARGET / SETTINGS_RUN);
    apply_setting(16'd0, 8'd0, 8'd0);
    random_traffic(ITEMS_TARGET / SETTINGS_RUN);
    apply_setting(16'($urandom_range(40, 2)), 8'($urandom_range(16, 1)),
                  8'($urandom_range(16, 1)));
    random_traffic(ITEMS_TARGET / SETTINGS_RUN);

    // Drain: the frame in progress runs out and every result comes back.
    settle_bus();

    $display("Drove %0d ticks under the reset values and seven loaded register settings;",
             ticks_sent);
    $display("checked %0d results, completed %0d frames and pin resets, %0d with a WAIT timeout.",
             results_checked, frames_done, timeouts);
    $display("%0d bad, %0d missing.", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: the slowest legal run stays well below this.
  initial begin
    #20_000_000;
    $display("Run did not complete within the time limit.");
    $display("FAIL");
    $finish;
  end

endmodule
